// ===== src/dhtl_pkg.sv =====
// Shared types and constants for the double-hashing lookup/insert unit.
`default_nettype none

package dhtl_pkg;

	localparam int KEY_W  = 32;
	localparam int ID_W   = 32;
	localparam int SLOT_W = 10;

	// Operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Request word
	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  new_id;
	} dhtl_req_t;

	// Result word
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   entry_id;
		logic              table_full;
	} dhtl_rsp_t;

	// Job class decided by the front end
	typedef enum logic {
		JOB_PROBE = 1'b0,
		JOB_ZERO  = 1'b1
	} dhtl_kind_t;

	// Fixed part of a queued job
	typedef struct packed {
		dhtl_kind_t       kind;
		logic             op;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  new_id;
	} dhtl_hdr_t;

	// One table slot
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} dhtl_entry_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_KEY,
		FR_PREP,
		FR_STEP,
		FR_PUSH
	} dhtl_front_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PROBE
	} dhtl_back_state_t;

endpackage

`default_nettype wire

// ===== src/dhtl_front.sv =====
// Front end: takes request words, works out home slot and probe step.
`default_nettype none

module dhtl_front #(
	parameter int TABLE_SLOTS    = 1021,
	parameter int SECOND_MODULUS = 1019
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	output logic                        busy,
	input  dhtl_pkg::dhtl_req_t         req,
	output logic                        job_valid,
	input  wire                         job_full,
	output dhtl_pkg::dhtl_hdr_t         job_hdr,
	output logic [$clog2(TABLE_SLOTS)-1:0] job_home,
	output logic [$clog2(TABLE_SLOTS)-1:0] job_step
);
	import dhtl_pkg::*;

	localparam int IW       = $clog2(TABLE_SLOTS);
	localparam int RW       = $clog2(SECOND_MODULUS);
	localparam int STW      = $clog2(SECOND_MODULUS + 1);
	localparam int PW       = 2 * KEY_W + 1;
	// Reciprocal ceil(2^(KEY_W + ceil(log2 d)) / d) gives the exact quotient of any key
	localparam int SHT      = KEY_W + IW;
	localparam int SHS      = KEY_W + RW;
	localparam longint unsigned MT_L =
		((64'd1 << SHT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
	localparam longint unsigned MS_L =
		((64'd1 << SHS) + 64'(SECOND_MODULUS) - 64'd1) / 64'(SECOND_MODULUS);
	localparam logic [KEY_W:0] MT = (KEY_W+1)'(MT_L);
	localparam logic [KEY_W:0] MS = (KEY_W+1)'(MS_L);
	localparam int QTW      = PW - SHT;
	localparam int QSW      = PW - SHS;
	// multiply, quotient times modulus, subtract
	localparam int KEY_CYC  = 3;
	localparam int STEP_CYC = 3;

	dhtl_front_state_t state_q, state_d;
	dhtl_hdr_t         hdr_q;
	logic [KEY_W-1:0]  opnd_q;
	logic [PW-1:0]     pt_q, ps_q;
	logic [KEY_W-1:0]  qt_q, qs_q;
	logic [IW-1:0]     r1_q;
	logic [RW-1:0]     r2_q;
	logic [IW-1:0]     r3_q;
	logic [1:0]        cnt_q;
	logic [STW-1:0]    step;
	logic              last_key, last_step;

	assign step      = STW'(SECOND_MODULUS) - STW'(r2_q);
	assign last_key  = (cnt_q == 2'(KEY_CYC - 1));
	assign last_step = (cnt_q == 2'(STEP_CYC - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (push) begin
					if (req.key == '0) state_d = FR_PUSH;
					else state_d = FR_KEY;
				end
			end
			FR_KEY:  if (last_key) state_d = FR_PREP;
			FR_PREP: state_d = FR_STEP;
			FR_STEP: if (last_step) state_d = FR_PUSH;
			FR_PUSH: if (!job_full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy      = (state_q != FR_IDLE);
		job_valid = (state_q == FR_PUSH);
		job_hdr   = hdr_q;
		job_home  = r1_q;
		job_step  = r3_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Remainder datapath: reciprocal multiply, back-multiply, subtract
	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				hdr_q.kind   <= (req.key == '0) ? JOB_ZERO : JOB_PROBE;
				hdr_q.op     <= req.op;
				hdr_q.key    <= req.key;
				hdr_q.new_id <= req.new_id;
				opnd_q       <= req.key;
				r1_q         <= '0;
				r2_q         <= '0;
				r3_q         <= '0;
				cnt_q        <= '0;
			end
			FR_KEY, FR_STEP: begin
				pt_q  <= PW'(opnd_q) * PW'(MT);
				ps_q  <= PW'(opnd_q) * PW'(MS);
				qt_q  <= KEY_W'(pt_q[PW-1 -: QTW]) * KEY_W'(TABLE_SLOTS);
				qs_q  <= KEY_W'(ps_q[PW-1 -: QSW]) * KEY_W'(SECOND_MODULUS);
				cnt_q <= cnt_q + 2'd1;
				if (state_q == FR_KEY) begin
					if (last_key) begin
						r1_q <= IW'(opnd_q - qt_q);
						r2_q <= RW'(opnd_q - qs_q);
					end
				end else if (last_step) begin
					r3_q <= IW'(opnd_q - qt_q);
				end
			end
			FR_PREP: begin
				// step lies in 1..SECOND_MODULUS, reduced by the table size next
				opnd_q <= KEY_W'(step);
				cnt_q  <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/dhtl_queue.sv =====
// Two-entry job queue between front and back ends.
`default_nettype none

module dhtl_queue #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          wr_en,
	input  wire  [W-1:0] wr_data,
	output logic         q_full,
	input  wire          rd_en,
	output logic [W-1:0] rd_data,
	output logic         q_empty
);
	import dhtl_pkg::*;

	logic [W-1:0] buf_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr, do_rd;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = buf_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) buf_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== src/dhtl_back.sv =====
// Back end: clears the table, walks the probe sequence, writes inserts, holds the result.
`default_nettype none

module dhtl_back #(
	parameter int TABLE_SLOTS = 1021
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            q_empty,
	output logic                           q_pop,
	input  dhtl_pkg::dhtl_hdr_t            job_hdr,
	input  wire [$clog2(TABLE_SLOTS)-1:0]  job_home,
	input  wire [$clog2(TABLE_SLOTS)-1:0]  job_step,
	output logic                           clearing,
	output logic                           empty,
	input  wire                            pop,
	output dhtl_pkg::dhtl_rsp_t            rsp
);
	import dhtl_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	// Table memory: key and id per slot
	dhtl_entry_t mem [TABLE_SLOTS];
	dhtl_entry_t rd_q;

	dhtl_back_state_t state_q, state_d;
	logic [IW-1:0] clr_q;
	dhtl_hdr_t     hdr_q;
	logic [IW-1:0] home_q, step_q, idx_q;
	logic [CW-1:0] cnt_q;
	dhtl_rsp_t     out_q;
	logic          out_v_q;

	logic          out_free, done, load, adv, we;
	logic [IW-1:0] ra, wa, nxt;
	logic [IW:0]   sum;
	dhtl_entry_t   wd;
	dhtl_rsp_t     res;
	logic [31:0]   idx_w, home_w;

	assign out_free = !out_v_q || pop;
	assign clearing = (state_q == BK_CLEAR);
	assign empty    = !out_v_q;
	assign rsp      = out_q;
	assign idx_w    = 32'(idx_q);
	assign home_w   = 32'(home_q);

	// Next probe slot, kept below the table size
	always_comb begin
		sum = {1'b0, idx_q} + {1'b0, step_q};
		if (sum >= (IW+1)'(TABLE_SLOTS)) sum = sum - (IW+1)'(TABLE_SLOTS);
		nxt = sum[IW-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == IW'(TABLE_SLOTS - 1)) state_d = BK_IDLE;
			BK_IDLE:  if (load) state_d = BK_PROBE;
			BK_PROBE: if (done) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Outputs and datapath controls
	always_comb begin
		q_pop = 1'b0;
		done  = 1'b0;
		load  = 1'b0;
		adv   = 1'b0;
		we    = 1'b0;
		wa    = idx_q;
		wd    = '0;
		ra    = idx_q;
		res   = '0;
		case (state_q)
			BK_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
			end
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (job_hdr.kind == JOB_ZERO) begin
						// reserved key: answer at once with all zero
						done = 1'b1;
					end else begin
						load = 1'b1;
						ra   = job_home;
					end
				end
			end
			BK_PROBE: begin
				res.slot = idx_w[SLOT_W-1:0];
				if (rd_q.key == '0) begin
					// empty slot: miss, store on insert
					done = 1'b1;
					if (hdr_q.op == OP_INSERT) begin
						we           = 1'b1;
						wd.key       = hdr_q.key;
						wd.id        = hdr_q.new_id;
						res.entry_id = hdr_q.new_id;
					end
				end else if (rd_q.key == hdr_q.key) begin
					done         = 1'b1;
					res.found    = 1'b1;
					res.entry_id = rd_q.id;
				end else if (cnt_q == CW'(TABLE_SLOTS)) begin
					// every slot probed
					done           = 1'b1;
					res.slot       = home_w[SLOT_W-1:0];
					res.table_full = 1'b1;
				end else begin
					adv = 1'b1;
					ra  = nxt;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + IW'(1);
			if (done) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	// Probe datapath and result word
	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q  <= job_hdr;
			home_q <= job_home;
			step_q <= job_step;
			idx_q  <= job_home;
			cnt_q  <= CW'(1);
		end else if (adv) begin
			idx_q <= nxt;
			cnt_q <= cnt_q + CW'(1);
		end
		if (done) out_q <= res;
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

endmodule

`default_nettype wire

// ===== src/double_hash_table_lookup_insert_unit.sv =====
// Top level of the double-hashing hash table lookup/insert unit.
//
//  channel  | handshake        | word                       | meaning
//  ---------+------------------+----------------------------+-----------------------------
//  request  | push / full      | req  (op, key, new_id)     | lookup, or lookup and insert
//  result   | empty / pop      | rsp  (found, slot,         | one word per request
//           |                  |       entry_id, table_full)|
//
// After reset the table is cleared one slot per cycle, and full stays high until every
// slot is clear. The front end reduces the key by both moduli (reciprocal multiply,
// quotient times modulus, subtract), forms the step, reduces it by the table size and
// hands the job over: full stays high from a request until the hand-over (a zero key
// goes straight to it), and longer while the queue is full. The back end starts a job
// from the queue and then probes slot after slot in the table memory, which has separate
// read and write ports; the two ends overlap through a two-entry queue. A result waiting
// in the output register holds back the back end, and the front end once the queue fills.
`default_nettype none

module double_hash_table_lookup_insert_unit #(
	parameter int TABLE_SLOTS    = 1021,
	parameter int SECOND_MODULUS = 1019
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  dhtl_pkg::dhtl_req_t req,
	output logic                empty,
	input  wire                 pop,
	output dhtl_pkg::dhtl_rsp_t rsp
);
	import dhtl_pkg::*;

	localparam int IW  = $clog2(TABLE_SLOTS);
	localparam int JOB_W = $bits(dhtl_hdr_t) + 2 * IW;

	logic          fr_busy, clearing;
	logic          job_valid, job_full, q_empty, q_pop;
	dhtl_hdr_t     fr_hdr, bk_hdr;
	logic [IW-1:0] fr_home, fr_step, bk_home, bk_step;
	logic [JOB_W-1:0] q_din, q_dout;

	// No requests while busy or while the table is being cleared
	assign full = fr_busy || clearing;

	dhtl_front #(
		.TABLE_SLOTS    (TABLE_SLOTS),
		.SECOND_MODULUS (SECOND_MODULUS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push && !full),
		.busy      (fr_busy),
		.req       (req),
		.job_valid (job_valid),
		.job_full  (job_full),
		.job_hdr   (fr_hdr),
		.job_home  (fr_home),
		.job_step  (fr_step)
	);

	assign q_din = {fr_hdr, fr_home, fr_step};
	assign {bk_hdr, bk_home, bk_step} = q_dout;

	dhtl_queue #(
		.W (JOB_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (q_din),
		.q_full  (job_full),
		.rd_en   (q_pop),
		.rd_data (q_dout),
		.q_empty (q_empty)
	);

	dhtl_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.job_hdr  (bk_hdr),
		.job_home (bk_home),
		.job_step (bk_step),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ===== src/dhtl_check.sv =====
// Port-level checks for the lookup/insert unit, bound to the top level.
`default_nettype none

module dhtl_check (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 push,
	input wire                 full,
	input dhtl_pkg::dhtl_req_t req,
	input wire                 empty,
	input wire                 pop,
	input dhtl_pkg::dhtl_rsp_t rsp
);
	import dhtl_pkg::*;

	// A waiting result word stays put until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(rsp))
		else $error("result word changed while not popped");

	// A full-table result is never a hit and carries no id
	a_full_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.table_full |-> !rsp.found && rsp.entry_id == '0)
		else $error("table_full result with hit or id");

	// Right after reset the table clear is running: no requests, no results
	a_post_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full && empty)
		else $error("unit not in clearing pass after reset");

	// A waiting result word carries no unknown bits
	a_rsp_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(rsp))
		else $error("unknown bits in result word");

endmodule

bind double_hash_table_lookup_insert_unit dhtl_check u_check (.*);

`default_nettype wire

// ===== test/double_hash_table_lookup_insert_unit_tb.sv =====
// Self-checking testbench for the double-hashing lookup/insert unit.
`default_nettype none

module double_hash_table_lookup_insert_unit_tb;
	import dhtl_pkg::*;

	localparam int unsigned SLOTS      = 1021;
	localparam int unsigned STRIDE_MOD = 1019;
	// Cycles with no word moving on either side before the run is declared hung
	localparam int unsigned STALL_LIMIT = 10000;
	// Drain time after the last result: front end plus a full sweep of the table
	localparam int unsigned DRAIN_CYCLES = 1100;
	// Kept short: filling the table for the full-table case takes most of the run
	localparam int unsigned RANDOM_WORDS = 40;

	typedef struct {
		dhtl_req_t   word;
		int unsigned pace;
	} stim_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	dhtl_req_t req    = '0;
	logic      full;
	logic      empty;
	dhtl_rsp_t rsp;

	// Idle percentages per pacing phase: sender / receiver
	int unsigned tx_idle [3] = '{16, 51, 0};
	int unsigned rx_idle [3] = '{51, 16, 0};
	int unsigned pace        = 0;

	stim_t     pending_words [$];
	dhtl_rsp_t expected_results [$];

	// Shadow copy of the table contents
	logic [KEY_W-1:0] shadow_key [SLOTS] = '{default: '0};
	logic [ID_W-1:0]  shadow_id  [SLOTS] = '{default: '0};

	// Keys sent with inserts, for generating hits and collisions
	logic [KEY_W-1:0] known_keys [$];
	bit               inserted [logic [KEY_W-1:0]];

	int unsigned errors       = 0;
	int unsigned stall_cycles = 0;

	double_hash_table_lookup_insert_unit #(
		.TABLE_SLOTS    (SLOTS),
		.SECOND_MODULUS (STRIDE_MOD)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic log_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	// Probe the shadow table for one request word, updating it on an insert miss
	function automatic dhtl_rsp_t probe_table(input dhtl_req_t w);
		dhtl_rsp_t   r;
		int unsigned home;
		int unsigned stride;
		int unsigned at;
		r = '0;
		// zero key is reserved: no probe, nothing written
		if (w.key == '0)
			return r;
		home   = w.key % SLOTS;
		stride = (STRIDE_MOD - (w.key % STRIDE_MOD)) % SLOTS;
		at     = home;
		for (int unsigned n = 0; n < SLOTS; n++) begin
			if (shadow_key[at] == '0) begin
				r.slot = at[SLOT_W-1:0];
				if (w.op == OP_INSERT) begin
					shadow_key[at] = w.key;
					shadow_id[at]  = w.new_id;
					r.entry_id     = w.new_id;
				end
				return r;
			end
			if (shadow_key[at] == w.key) begin
				r.found    = 1'b1;
				r.slot     = at[SLOT_W-1:0];
				r.entry_id = shadow_id[at];
				return r;
			end
			at = (at + stride) % SLOTS;
		end
		// every slot visited without a match or a hole
		r.slot       = home[SLOT_W-1:0];
		r.table_full = 1'b1;
		return r;
	endfunction

	task automatic add_word(input logic op, input logic [KEY_W-1:0] key,
			input logic [ID_W-1:0] id);
		stim_t s;
		s.word.op     = op;
		s.word.key    = key;
		s.word.new_id = id;
		s.pace        = 0;
		pending_words.push_back(s);
		if (op == OP_INSERT && key != '0 && !inserted.exists(key)) begin
			inserted[key] = 1'b1;
			known_keys.push_back(key);
		end
	endtask

	function automatic logic [KEY_W-1:0] unused_key();
		logic [KEY_W-1:0] k;
		do
			k = $urandom();
		while (k == '0 || inserted.exists(k));
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] some_known_key();
		return known_keys[$urandom_range(known_keys.size() - 1)];
	endfunction

	// Request side: take words from the pending queue, idle at random
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expected_results.push_back(probe_table(req));
				void'(pending_words.pop_front());
			end
			if (push && full) begin
				// hold the word until it is taken
			end else if (pending_words.size() != 0 &&
					$urandom_range(99) >= tx_idle[pending_words[0].pace]) begin
				push <= 1'b1;
				req  <= pending_words[0].word;
				pace <= pending_words[0].pace;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result side: pop at random and check against the oldest expectation
	always @(posedge clk) begin : result_check
		dhtl_rsp_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					log_error($sformatf("result word with nothing expected: %h", rsp));
				end else begin
					want = expected_results.pop_front();
					if (rsp.found !== want.found)
						log_error($sformatf("found %b, want %b", rsp.found, want.found));
					if (rsp.slot !== want.slot)
						log_error($sformatf("slot %0d, want %0d", rsp.slot, want.slot));
					if (rsp.entry_id !== want.entry_id)
						log_error($sformatf("entry_id %h, want %h",
							rsp.entry_id, want.entry_id));
					if (rsp.table_full !== want.table_full)
						log_error($sformatf("table_full %b, want %b",
							rsp.table_full, want.table_full));
				end
			end
			pop <= ($urandom_range(99) >= rx_idle[pace]);
		end
	end

	// Watchdog: no word moving for too long means the block is hung
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("double_hash_table_lookup_insert_unit_tb failed");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		logic [KEY_W-1:0] k;

		// Directed: reserved key, hits, misses, collision chains, extreme keys and ids
		add_word(OP_LOOKUP, 32'd0, 32'h0);
		add_word(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
		add_word(OP_LOOKUP, 32'd1, 32'h1234_5678);
		add_word(OP_INSERT, 32'd1, 32'h0);
		add_word(OP_INSERT, 32'd1, 32'h0000_007B);
		add_word(OP_LOOKUP, 32'd1, 32'h0);
		// same home slot as key 1
		add_word(OP_INSERT, 32'd1 + SLOTS, 32'hFFFF_FFFF);
		add_word(OP_INSERT, 32'd1 + 2 * SLOTS, 32'h0BAD_F00D);
		add_word(OP_LOOKUP, 32'd1 + 2 * SLOTS, 32'h0);
		add_word(OP_LOOKUP, 32'd1 + 3 * SLOTS, 32'h0);
		add_word(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		add_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		// highest slot index
		add_word(OP_INSERT, 32'd1020, 32'h1);
		add_word(OP_LOOKUP, 32'd1020, 32'h0);
		// largest probe step, home slot 0
		add_word(OP_INSERT, STRIDE_MOD * SLOTS, 32'h8000_0000);
		// step of one, home slot 0, walks into the key 1 chain
		add_word(OP_INSERT, 32'd509 * SLOTS, 32'h7FFF_FFFF);
		add_word(OP_LOOKUP, 32'd509 * SLOTS, 32'h0);
		add_word(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		add_word(OP_LOOKUP, 32'd0, 32'hFFFF_FFFF);
		add_word(OP_INSERT, 32'h1234_5678, 32'h5);
		add_word(OP_LOOKUP, 32'h8000_0000, 32'h0);

		// Random: mostly inserts and lookups of stored keys, some noise
		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			r = $urandom_range(99);
			if (r < 45)
				add_word(OP_INSERT, unused_key(), $urandom());
			else if (r < 70)
				add_word(OP_LOOKUP, some_known_key(), $urandom());
			else if (r < 80)
				add_word(OP_INSERT, some_known_key(), $urandom());
			else if (r < 92)
				add_word(OP_LOOKUP, unused_key(), $urandom());
			else if (r < 96)
				add_word(logic'($urandom_range(1)), 32'd0, $urandom());
			else
				add_word(OP_INSERT, some_known_key() + SLOTS * $urandom_range(1, 8),
					$urandom());
		end

		// Fill the remaining slots with fresh keys, then work on a full table
		while (inserted.num() < SLOTS)
			add_word(OP_INSERT, unused_key(), $urandom());
		for (int unsigned i = 0; i < 6; i++) begin
			add_word(OP_LOOKUP, unused_key(), $urandom());
			add_word(OP_LOOKUP, some_known_key(), $urandom());
			k = unused_key();
			add_word(OP_INSERT, k, $urandom());
			// a refused insert leaves the key absent
			inserted.delete(k);
			add_word(OP_INSERT, some_known_key(), $urandom());
		end
		add_word(OP_INSERT, 32'd0, $urandom());

		// Spread the three pacing phases evenly over the whole run
		foreach (pending_words[j])
			pending_words[j].pace = unsigned'((j * 3) / pending_words.size());

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("double_hash_table_lookup_insert_unit_tb passed");
		else
			$display("double_hash_table_lookup_insert_unit_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
